[rtl/bfba_pkg.sv]
package bfba_pkg;

  // field widths of the command, configuration and result ports
  localparam int CMD_W   = 1;
  localparam int IDX_W   = 4;
  localparam int SIZE_W  = 16;
  localparam int COUNT_W = 5;

  // blocks in use never exceed this many, whatever the table depth
  localparam int SCAN_LIMIT = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b1;

  // fit modes
  localparam logic MODE_BEST  = 1'b0;
  localparam logic MODE_FIRST = 1'b1;

  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

endpackage

[rtl/bfba_ram.sv]
module bfba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/best_fit_block_allocator.sv]
// A load transaction is written in the cycle it is taken and gives no result.
// An allocate transaction scans the blocks in use in ST_SCAN, compares the last entry
// read in ST_DRAIN, then writes back in ST_WRITE; busy holds off new commands until idle.
// Throughput is set by the single table read port: one entry scanned per cycle.
// Reset (rst, synchronous): idle, no strobe, block_count = 16, best fit; table
// contents undefined until loaded. The receiver cannot stall: done lasts one cycle.
module best_fit_block_allocator
  import bfba_pkg::*;
#(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     command,
  input  logic [IDX_W-1:0]     table_index,
  input  logic [SIZE_W-1:0]    size_value,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data,
  // result side
  output logic                 done,
  output logic                 granted,
  output logic [IDX_W-1:0]     chosen_block,
  output logic [SIZE_W-1:0]    size_left
);

  localparam int AW  = $clog2(MAX_BLOCKS);
  // compare width: wide enough for both a table entry and a request
  localparam int CW  = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;
  // cap on blocks in use
  localparam int CAP = (MAX_BLOCKS < SCAN_LIMIT) ? MAX_BLOCKS : SCAN_LIMIT;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;  // issue one table read per cycle
  localparam logic [1:0] ST_DRAIN = 2'd2;  // last read data being compared
  localparam logic [1:0] ST_WRITE = 2'd3;  // write back and present result

  logic [1:0]           state;
  logic [COUNT_W-1:0]   block_count;
  logic                 fit_mode;

  // request being served
  logic [SIZE_W-1:0]    req;
  logic [IDX_W-1:0]     scan_addr;
  logic [IDX_W-1:0]     last_addr;

  // read pipeline: index of the entry whose data is on rd_data
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic [SIZE_BITS-1:0] rd_data;

  // running choice
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] pick_val;

  logic [COUNT_W-1:0]   in_use;
  logic [COUNT_W-1:0]   in_use_m1;
  logic                 accept;
  logic                 load_ok;
  logic                 hit;
  logic [CW-1:0]        left_cw;
  logic [SIZE_BITS-1:0] new_val;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // blocks in use saturate at the table depth (and at sixteen)
  always_comb begin
    if (block_count > COUNT_W'(CAP)) begin
      in_use = COUNT_W'(CAP);
    end else begin
      in_use = block_count;
    end
  end
  assign in_use_m1 = in_use - COUNT_W'(1);

  // a load beyond the table is dropped
  assign load_ok = (32'(table_index) < MAX_BLOCKS);

  // candidate test on the entry just read: fits, and either the first fit seen or,
  // in best-fit mode, strictly smaller than the current choice (ties keep lowest index)
  assign hit = rd_valid && (CW'(rd_data) >= CW'(req)) &&
               (!found || (fit_mode == MODE_BEST && rd_data < pick_val));

  // remainder after the grant, wrapped to the entry width
  assign left_cw = CW'(pick_val) - CW'(req);
  assign new_val = left_cw[SIZE_BITS-1:0];

  // single write port: loads only while idle, write-back only in ST_WRITE
  always_comb begin
    if (state == ST_WRITE) begin
      ram_we    = found;
      ram_waddr = AW'(pick);
      ram_wdata = new_val;
    end else begin
      ram_we    = accept && (command == CMD_LOAD) && load_ok;
      ram_waddr = AW'(table_index);
      ram_wdata = SIZE_BITS'(size_value);
    end
  end

  bfba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(scan_addr)),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      rd_valid    <= 1'b0;
      block_count <= BLOCK_COUNT_RESET;
      fit_mode    <= MODE_BEST;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_COUNT: begin
            block_count <= cfg_data;
          end
          REG_FIT_MODE: begin
            fit_mode <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept && command == CMD_ALLOC) begin
            req       <= size_value;
            found     <= 1'b0;
            pick      <= '0;
            pick_val  <= '0;
            scan_addr <= '0;
            last_addr <= in_use_m1[IDX_W-1:0];
            // nothing in use: straight to a refusal
            if (in_use == '0) begin
              state <= ST_WRITE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_valid <= 1'b1;
          rd_idx   <= scan_addr;
          if (scan_addr == last_addr) begin
            state <= ST_DRAIN;
          end else begin
            scan_addr <= scan_addr + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          done    <= 1'b1;
          granted <= found;
          if (found) begin
            chosen_block <= pick;
            size_left    <= SIZE_W'(new_val);
          end else begin
            chosen_block <= '0;
            size_left    <= '0;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // compare stage, one entry per cycle behind the read
      if (hit) begin
        found    <= 1'b1;
        pick     <= rd_idx;
        pick_val <= rd_data;
      end
    end
  end

endmodule
